// ----- rtl/stlb_pkg.sv -----
// package for the split tlb: geometry constants, operation and register codes,
// transaction and entry types
// no dependencies
`timescale 1ns / 1ps

package stlb_pkg;

  // geometry (ENTRIES must be a power of two, 4 to 1024)
  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned NUM_TLBS  = 2;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned TSEL_W    = 1;
  localparam logic        TSEL_MASK = (NUM_TLBS > 1) ? 1'b1 : 1'b0;

  // address layout
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned TAG_W      = 32 - PAGE_SHIFT;
  localparam int unsigned FRAME_W    = 32 - PAGE_SHIFT;
  localparam int unsigned PTE_DIRTY  = 6;
  localparam int unsigned PTE_GLOBAL = 8;

  // allowed-access bitmap indexed by {wp, is_user, user, writable, is_write}
  localparam logic [31:0] ACCESS_TABLE = 32'hd0dd_d0ff;

  // operation codes, the rest do nothing
  localparam logic [2:0] OP_LOOKUP       = 3'd0;
  localparam logic [2:0] OP_FILL         = 3'd1;
  localparam logic [2:0] OP_FLUSH_NONGLB = 3'd2;
  localparam logic [2:0] OP_FLUSH_ALL    = 3'd3;
  localparam logic [2:0] OP_FLUSH_PAGE   = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROTECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_ENABLE = 1'd1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] linear_addr;
    logic        is_write;
    logic        is_user;
    logic        is_code;
    logic [31:0] pte_value;
    logic        fill_writable;
    logic        fill_user;
  } tlb_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] phys_addr;
  } tlb_rsp_t;

  // ram entry; valid and global bits live in flops
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               writable;
    logic               user;
    logic               dirty;
    logic [FRAME_W-1:0] frame;
  } tlb_entry_t;

  localparam int unsigned ENTRY_W = $bits(tlb_entry_t);

endpackage

// ----- rtl/stlb_req_if.sv -----
// request channel interface (valid/ready with request payload)
// depends on stlb_pkg
`timescale 1ns / 1ps

interface stlb_req_if;
  import stlb_pkg::*;

  logic     valid;
  logic     ready;
  tlb_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/stlb_rsp_if.sv -----
// response channel interface (valid/ready with lookup result payload)
// depends on stlb_pkg
`timescale 1ns / 1ps

interface stlb_rsp_if;
  import stlb_pkg::*;

  logic     valid;
  logic     ready;
  tlb_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/stlb_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module stlb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/split_tlb_lookup_fill_flush_unit.sv -----
// split data/code tlb for 4 KiB pages: lookup, fill and three flush kinds
// depends on stlb_pkg, stlb_req_if, stlb_rsp_if, stlb_ram
`timescale 1ns / 1ps

// channel  | dir | handshake       | payload
// req_i    | in  | valid / ready   | operation, linear_addr, is_write, is_user,
//          |     |                 | is_code, pte_value, fill_writable, fill_user
// rsp_o    | out | valid / ready   | hit, phys_addr
// cfg      | in  | cfg_we_i        | cfg_idx_i, cfg_data_i
//
// one transaction per cycle sustained while the output is not stalled: the first
// stage reads the entry ram, the second checks, updates state and loads
// the output register. a fill to the entry read in the same cycle is forwarded.
// reset clears all valid bits at once, no clearing pass; entry rams have no reset.
// a stalled output holds the second stage, which in turn holds the input.

module split_tlb_lookup_fill_flush_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  stlb_req_if.sink                           req_i,
  stlb_rsp_if.source                         rsp_o,
  input  logic                               cfg_we_i,
  input  logic [stlb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic                               cfg_data_i
);
  import stlb_pkg::*;

  // configuration registers
  logic write_protect_q;
  logic global_enable_q;

  // per-entry valid and global flops
  logic [NUM_TLBS-1:0][ENTRIES-1:0] valid_q, valid_d;
  logic [NUM_TLBS-1:0][ENTRIES-1:0] global_q, global_d;

  // pipeline control and payload
  logic          s1_valid_q;
  tlb_req_t      s1_req_q;
  logic          s1_done;
  logic          in_accept;
  logic          out_valid_q;
  tlb_rsp_t      out_q;

  // forwarding of a fill that lands on the entry just read
  logic [NUM_TLBS-1:0] fwd_hit_q;
  tlb_entry_t          fwd_data_q;

  // input side decode
  logic [IDX_W-1:0]  in_idx;

  // second stage decode
  logic [IDX_W-1:0]  s1_idx;
  logic [TAG_W-1:0]  s1_tag;
  logic [TSEL_W-1:0] s1_tsel;
  tlb_entry_t        ram_rdata [NUM_TLBS];
  tlb_entry_t        rd_ent    [NUM_TLBS];
  tlb_entry_t        sel_ent;
  tlb_entry_t        fill_ent;
  logic              sel_valid;
  logic [4:0]        prot_idx;
  logic              lookup_hit;
  tlb_rsp_t          result;
  logic              fill_we;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_protect_q <= 1'b0;
      global_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WRITE_PROTECT: write_protect_q <= cfg_data_i;
        CFG_GLOBAL_ENABLE: global_enable_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_done    = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_done;
  assign in_accept  = req_i.valid && req_i.ready;

  assign in_idx  = req_i.payload.linear_addr[PAGE_SHIFT +: IDX_W];

  assign s1_idx  = s1_req_q.linear_addr[PAGE_SHIFT +: IDX_W];
  assign s1_tag  = s1_req_q.linear_addr[31:PAGE_SHIFT];
  assign s1_tsel = s1_req_q.is_code & TSEL_MASK;
  assign fill_we = s1_done && (s1_req_q.operation == OP_FILL);

  // entry written by a fill
  always_comb begin
    fill_ent.tag      = s1_tag;
    fill_ent.writable = s1_req_q.fill_writable;
    fill_ent.user     = s1_req_q.fill_user;
    fill_ent.dirty    = s1_req_q.pte_value[PTE_DIRTY];
    fill_ent.frame    = s1_req_q.pte_value[31:PAGE_SHIFT];
  end

  // one entry ram per tlb
  for (genvar t = 0; t < NUM_TLBS; t++) begin : g_tlb
    stlb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (fill_we && (s1_tsel == TSEL_W'(t))),
      .waddr_i (s1_idx),
      .wdata_i (fill_ent),
      .re_i    (in_accept),
      .raddr_i (in_idx),
      .rdata_o (ram_rdata[t])
    );

    assign rd_ent[t] = fwd_hit_q[t] ? fwd_data_q : ram_rdata[t];
  end

  // stage one registers and forwarding capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        for (int t = 0; t < NUM_TLBS; t++) begin
          fwd_hit_q[t] <= fill_we && (s1_tsel == TSEL_W'(t)) && (s1_idx == in_idx);
        end
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q   <= req_i.payload;
      fwd_data_q <= fill_ent;
    end
  end

  // lookup check
  assign sel_ent   = rd_ent[s1_tsel];
  assign sel_valid = valid_q[s1_tsel][s1_idx];
  assign prot_idx  = {write_protect_q, s1_req_q.is_user, sel_ent.user,
                      sel_ent.writable, s1_req_q.is_write};
  assign lookup_hit = (s1_req_q.operation == OP_LOOKUP) && sel_valid &&
                      (sel_ent.tag == s1_tag) && ACCESS_TABLE[prot_idx] &&
                      (!s1_req_q.is_write || sel_ent.dirty);

  always_comb begin
    result.hit       = lookup_hit;
    result.phys_addr = lookup_hit ?
                       {sel_ent.frame, s1_req_q.linear_addr[PAGE_SHIFT-1:0]} : 32'd0;
  end

  // valid and global bit updates
  always_comb begin
    valid_d  = valid_q;
    global_d = global_q;
    if (s1_done) begin
      unique case (s1_req_q.operation)
        OP_FILL: begin
          valid_d[s1_tsel][s1_idx]  = 1'b1;
          global_d[s1_tsel][s1_idx] = s1_req_q.pte_value[PTE_GLOBAL];
        end
        OP_FLUSH_NONGLB: begin
          for (int t = 0; t < NUM_TLBS; t++) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (!(global_enable_q && global_q[t][i])) begin
                valid_d[t][i] = 1'b0;
              end
            end
          end
        end
        OP_FLUSH_ALL: begin
          valid_d = '0;
        end
        OP_FLUSH_PAGE: begin
          for (int t = 0; t < NUM_TLBS; t++) begin
            if (valid_q[t][s1_idx] && (rd_ent[t].tag == s1_tag)) begin
              valid_d[t][s1_idx] = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      global_q <= '0;
    end else begin
      valid_q  <= valid_d;
      global_q <= global_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done) begin
      out_q <= result;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

`ifndef SYNTHESIS
  // a fill forwards into at most one tlb
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(fwd_hit_q))
    else $error("fill forwarded into more than one tlb");

  // flush-all leaves no valid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_done && (s1_req_q.operation == OP_FLUSH_ALL)) |=> (valid_q == '0))
    else $error("valid entries left after flush-all");

  // a completed fill leaves its entry valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |=> valid_q[$past(s1_tsel)][$past(s1_idx)])
    else $error("filled entry not valid");

  // a miss never reports an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.hit) |-> (out_q.phys_addr == 32'd0))
    else $error("miss with nonzero physical address");
`endif

endmodule
